// ----- hw/rtl/round_robin_thread_scheduler_defines.svh -----
// Assertion macros shared by the scheduler RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RRTS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/rrts_pkg.sv -----
// Types and codes for the round-robin thread scheduler.
// No dependencies; used by the channel interfaces and all RTL modules.
package rrts_pkg;

   typedef logic [2:0]  op_type;
   typedef logic [2:0]  thread_state_type;
   typedef logic [1:0]  result_code_type;
   typedef logic [15:0] pid_type;
   typedef logic [16:0] pid_ext_type;
   typedef logic [63:0] time_type;

   localparam op_type OP_CREATE   = 3'd0;
   localparam op_type OP_SCHEDULE = 3'd1;
   localparam op_type OP_EXIT     = 3'd2;
   localparam op_type OP_SLEEP    = 3'd3;
   localparam op_type OP_WAIT     = 3'd4;
   localparam op_type OP_TICK     = 3'd5;
   localparam op_type OP_REAP     = 3'd6;
   localparam op_type OP_FIND     = 3'd7;

   localparam thread_state_type ST_READY      = 3'd0;
   localparam thread_state_type ST_RUNNING    = 3'd1;
   localparam thread_state_type ST_WAITING    = 3'd2;
   localparam thread_state_type ST_SLEEPING   = 3'd3;
   localparam thread_state_type ST_TERMINATED = 3'd4;

   localparam result_code_type RC_OK             = 2'd0;
   localparam result_code_type RC_TABLE_FULL     = 2'd1;
   localparam result_code_type RC_NOT_FOUND      = 2'd2;
   localparam result_code_type RC_PIDS_EXHAUSTED = 2'd3;

   localparam pid_ext_type PID_NONE  = 17'h1FFFF;
   localparam pid_ext_type PID_LIMIT = 17'h0FFFF;
   localparam pid_ext_type PID_FIRST = 17'h00001;

endpackage

// ----- hw/rtl/rrts_if.sv -----
// Valid/ready channel interfaces for scheduler requests and responses.
// Depends on rrts_pkg for payload types.
interface rrts_req_if;
   logic                   valid;
   logic                   ready;
   rrts_pkg::op_type       operation;
   logic                   is_user;
   logic                   make_foreground;
   rrts_pkg::pid_type      target_pid;
   rrts_pkg::time_type     wake_deadline;
   rrts_pkg::time_type     now_time;

   modport source (output valid, operation, is_user, make_foreground, target_pid,
                   wake_deadline, now_time, input ready);
   modport sink (input valid, operation, is_user, make_foreground, target_pid,
                 wake_deadline, now_time, output ready);
endinterface

interface rrts_rsp_if;
   logic                      valid;
   logic                      ready;
   rrts_pkg::result_code_type result_code;
   rrts_pkg::pid_type         result_pid;
   rrts_pkg::thread_state_type found_status;
   rrts_pkg::pid_type         current_pid;
   logic                      user_alive;
   logic                      foreground_alive;

   modport source (output valid, result_code, result_pid, found_status, current_pid,
                   user_alive, foreground_alive, input ready);
   modport sink (input valid, result_code, result_pid, found_status, current_pid,
                 user_alive, foreground_alive, output ready);
endinterface

// ----- hw/rtl/rrts_deadline_ram.sv -----
// Sleep deadline store: one write port, one registered read port.
// Depends on rrts_pkg for the time type.
module rrts_deadline_ram #(
   parameter int ADDR_W = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  rrts_pkg::time_type    wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output rrts_pkg::time_type    rd_data
);

   rrts_pkg::time_type mem [2**ADDR_W];
   rrts_pkg::time_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/round_robin_thread_scheduler.sv -----
// Round-robin thread scheduler: slot table, ring walks and status scan.
// Depends on rrts_pkg, rrts_if, rrts_deadline_ram and the defines header.
//
// Usage: one request enters on req_chan (valid/ready); exactly one response
// leaves on rsp_chan. The block works on one request at a time: req_chan.ready
// is high only while it is idle. A request is registered, then handled in an
// operation step, then a ring walk runs for schedule, exit and reap (one slot
// per cycle), then a status scan covers all slots through the registered read
// port of the deadline store, then the response register is loaded.
// The response sits in an output register; when the receiver stalls, the
// finished item holds in the final step until the register frees.
// Reset (synchronous, active high) leaves only the idle slot in the ring,
// running, with pid counter one and no foreground pid. Sleep deadlines are
// not cleared; they are written before any read.
`include "round_robin_thread_scheduler_defines.svh"

module round_robin_thread_scheduler #(
   parameter int THREAD_SLOTS = 16
) (
   input logic        clock,
   input logic        reset,
   rrts_req_if.sink   req_chan,
   rrts_rsp_if.source rsp_chan
);

   localparam int SW = $clog2(THREAD_SLOTS);
   localparam int PW = SW + 1;
   localparam int CW = SW + 1;
   localparam logic [PW-1:0] PARENT_NONE = PW'(THREAD_SLOTS);
   localparam logic [CW-1:0] SLOT_COUNT  = CW'(THREAD_SLOTS);
   localparam logic [SW-1:0] IDLE_SLOT   = '0;

   localparam logic [2:0] FSM_IDLE   = 3'd0;
   localparam logic [2:0] FSM_OP     = 3'd1;
   localparam logic [2:0] FSM_SCHED  = 3'd2;
   localparam logic [2:0] FSM_REAP   = 3'd3;
   localparam logic [2:0] FSM_SCAN   = 3'd4;
   localparam logic [2:0] FSM_FINISH = 3'd5;

   // slot table
   logic                       used_ff    [THREAD_SLOTS];
   logic                       used_in    [THREAD_SLOTS];
   rrts_pkg::pid_type          pid_ff     [THREAD_SLOTS];
   rrts_pkg::pid_type          pid_in     [THREAD_SLOTS];
   rrts_pkg::thread_state_type state_ff   [THREAD_SLOTS];
   rrts_pkg::thread_state_type state_in   [THREAD_SLOTS];
   logic                       user_ff    [THREAD_SLOTS];
   logic                       user_in    [THREAD_SLOTS];
   logic [PW-1:0]              parent_ff  [THREAD_SLOTS];
   logic [PW-1:0]              parent_in  [THREAD_SLOTS];
   rrts_pkg::pid_ext_type      waitfor_ff [THREAD_SLOTS];
   rrts_pkg::pid_ext_type      waitfor_in [THREAD_SLOTS];
   logic [SW-1:0]              succ_ff    [THREAD_SLOTS];
   logic [SW-1:0]              succ_in    [THREAD_SLOTS];

   logic [SW-1:0]         run_ff, run_in;
   logic [SW-1:0]         head_ff, head_in;
   rrts_pkg::pid_ext_type pid_ctr_ff, pid_ctr_in;
   rrts_pkg::pid_ext_type fg_pid_ff, fg_pid_in;

   logic [2:0] fsm_ff, fsm_in;

   // registered request
   rrts_pkg::op_type   op_ff, op_in;
   logic               is_user_ff, is_user_in;
   logic               make_fg_ff, make_fg_in;
   rrts_pkg::pid_type  target_ff, target_in;
   rrts_pkg::time_type time_ff, time_in;

   // walk and scan
   logic [SW-1:0] walk_cur_ff, walk_cur_in;
   logic [SW-1:0] walk_prev_ff, walk_prev_in;
   logic [SW-1:0] walk_first_ff, walk_first_in;
   logic [CW-1:0] walk_n_ff, walk_n_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic          proc_vld_ff, proc_vld_in;
   logic [SW-1:0] proc_idx_ff, proc_idx_in;

   logic                       ualive_ff, ualive_in;
   logic                       fg_found_ff, fg_found_in;
   logic                       fg_term_ff, fg_term_in;
   logic                       tgt_found_ff, tgt_found_in;
   rrts_pkg::thread_state_type tgt_state_ff, tgt_state_in;

   rrts_pkg::result_code_type  code_ff, code_in;
   rrts_pkg::pid_type          rpid_ff, rpid_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   rrts_pkg::result_code_type  rsp_code_ff, rsp_code_in;
   rrts_pkg::pid_type          rsp_pid_ff, rsp_pid_in;
   rrts_pkg::thread_state_type rsp_fstat_ff, rsp_fstat_in;
   rrts_pkg::pid_type          rsp_cur_ff, rsp_cur_in;
   logic                       rsp_ualive_ff, rsp_ualive_in;
   logic                       rsp_fgalive_ff, rsp_fgalive_in;

   // deadline store
   logic               dl_wr_en;
   logic [SW-1:0]      dl_wr_addr;
   rrts_pkg::time_type dl_wr_data;
   logic [SW-1:0]      dl_rd_addr;
   rrts_pkg::time_type dl_rd_data;

   logic          free_found;
   logic [SW-1:0] free_slot;
   logic          accept;

   rrts_deadline_ram #(.ADDR_W(SW)) u_deadline_ram (
      .clock   (clock),
      .wr_en   (dl_wr_en),
      .wr_addr (dl_wr_addr),
      .wr_data (dl_wr_data),
      .rd_addr (dl_rd_addr),
      .rd_data (dl_rd_data)
   );

   assign req_chan.ready = (fsm_ff == FSM_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.result_code      = rsp_code_ff;
   assign rsp_chan.result_pid       = rsp_pid_ff;
   assign rsp_chan.found_status     = rsp_fstat_ff;
   assign rsp_chan.current_pid      = rsp_cur_ff;
   assign rsp_chan.user_alive       = rsp_ualive_ff;
   assign rsp_chan.foreground_alive = rsp_fgalive_ff;

   // lowest free slot from 1 upward
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int k = THREAD_SLOTS - 1; k >= 1; k--) begin
         if (!used_ff[k]) begin
            free_found = 1'b1;
            free_slot  = SW'(k);
         end
      end
   end

   always_comb begin
      logic [SW-1:0]              sl;
      logic [SW-1:0]              cur;
      logic [SW-1:0]              nx;
      logic [SW-1:0]              sel;
      logic [PW-1:0]              par;
      logic [CW-1:0]              n_step;
      logic                       done;
      logic                       reap_it;
      logic                       fg_alive;
      rrts_pkg::thread_state_type st;

      for (int k = 0; k < THREAD_SLOTS; k++) begin
         used_in[k]    = used_ff[k];
         pid_in[k]     = pid_ff[k];
         state_in[k]   = state_ff[k];
         user_in[k]    = user_ff[k];
         parent_in[k]  = parent_ff[k];
         waitfor_in[k] = waitfor_ff[k];
         succ_in[k]    = succ_ff[k];
      end
      run_in        = run_ff;
      head_in       = head_ff;
      pid_ctr_in    = pid_ctr_ff;
      fg_pid_in     = fg_pid_ff;
      fsm_in        = fsm_ff;
      op_in         = op_ff;
      is_user_in    = is_user_ff;
      make_fg_in    = make_fg_ff;
      target_in     = target_ff;
      time_in       = time_ff;
      walk_cur_in   = walk_cur_ff;
      walk_prev_in  = walk_prev_ff;
      walk_first_in = walk_first_ff;
      walk_n_in     = walk_n_ff;
      scan_idx_in   = scan_idx_ff;
      proc_vld_in   = 1'b0;
      proc_idx_in   = proc_idx_ff;
      ualive_in     = ualive_ff;
      fg_found_in   = fg_found_ff;
      fg_term_in    = fg_term_ff;
      tgt_found_in  = tgt_found_ff;
      tgt_state_in  = tgt_state_ff;
      code_in       = code_ff;
      rpid_in       = rpid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_code_in    = rsp_code_ff;
      rsp_pid_in     = rsp_pid_ff;
      rsp_fstat_in   = rsp_fstat_ff;
      rsp_cur_in     = rsp_cur_ff;
      rsp_ualive_in  = rsp_ualive_ff;
      rsp_fgalive_in = rsp_fgalive_ff;
      dl_wr_en   = 1'b0;
      dl_wr_addr = '0;
      dl_wr_data = '0;
      dl_rd_addr = scan_idx_ff[SW-1:0];

      sl       = free_slot;
      cur      = run_ff;
      nx       = '0;
      sel      = '0;
      par      = PARENT_NONE;
      n_step   = walk_n_ff + CW'(1);
      done     = 1'b0;
      reap_it  = 1'b0;
      fg_alive = 1'b0;
      st       = rrts_pkg::ST_READY;

      case (fsm_ff)
         FSM_IDLE: begin
            if (accept) begin
               op_in        = req_chan.operation;
               is_user_in   = req_chan.is_user;
               make_fg_in   = req_chan.make_foreground;
               target_in    = req_chan.target_pid;
               time_in      = (req_chan.operation == rrts_pkg::OP_SLEEP) ?
                              req_chan.wake_deadline : req_chan.now_time;
               code_in      = rrts_pkg::RC_OK;
               rpid_in      = '0;
               ualive_in    = 1'b0;
               fg_found_in  = 1'b0;
               fg_term_in   = 1'b0;
               tgt_found_in = 1'b0;
               tgt_state_in = rrts_pkg::ST_READY;
               fsm_in       = FSM_OP;
            end
         end
         FSM_OP: begin
            scan_idx_in   = '0;
            walk_prev_in  = run_ff;
            walk_cur_in   = succ_ff[run_ff];
            walk_first_in = succ_ff[run_ff];
            walk_n_in     = '0;
            fsm_in        = FSM_SCAN;
            case (op_ff)
               rrts_pkg::OP_CREATE: begin
                  if (!free_found) begin
                     code_in = rrts_pkg::RC_TABLE_FULL;
                  end else if (pid_ctr_ff > rrts_pkg::PID_LIMIT) begin
                     code_in = rrts_pkg::RC_PIDS_EXHAUSTED;
                  end else begin
                     used_in[sl]    = 1'b1;
                     pid_in[sl]     = pid_ctr_ff[15:0];
                     pid_ctr_in     = pid_ctr_ff + 17'd1;
                     state_in[sl]   = rrts_pkg::ST_READY;
                     user_in[sl]    = is_user_ff;
                     parent_in[sl]  = is_user_ff ? {1'b0, run_ff} : PARENT_NONE;
                     waitfor_in[sl] = rrts_pkg::PID_NONE;
                     succ_in[sl]      = succ_ff[head_ff];
                     succ_in[head_ff] = sl;
                     dl_wr_en   = 1'b1;
                     dl_wr_addr = sl;
                     if (make_fg_ff) begin
                        fg_pid_in = {1'b0, pid_ctr_ff[15:0]};
                     end
                     rpid_in = pid_ctr_ff[15:0];
                  end
               end
               rrts_pkg::OP_SCHEDULE: begin
                  fsm_in = FSM_SCHED;
               end
               rrts_pkg::OP_EXIT: begin
                  if (cur != IDLE_SLOT) begin
                     par           = parent_ff[cur];
                     state_in[cur] = rrts_pkg::ST_TERMINATED;
                     if (fg_pid_ff == {1'b0, pid_ff[cur]}) begin
                        fg_pid_in = rrts_pkg::PID_NONE;
                     end
                     // wake a parent blocked on this pid
                     if (par != PARENT_NONE &&
                         state_ff[par[SW-1:0]] == rrts_pkg::ST_WAITING &&
                         waitfor_ff[par[SW-1:0]] == {1'b0, pid_ff[cur]}) begin
                        state_in[par[SW-1:0]]   = rrts_pkg::ST_READY;
                        waitfor_in[par[SW-1:0]] = rrts_pkg::PID_NONE;
                     end
                  end
                  fsm_in = FSM_SCHED;
               end
               rrts_pkg::OP_SLEEP: begin
                  state_in[run_ff] = rrts_pkg::ST_SLEEPING;
                  dl_wr_en   = 1'b1;
                  dl_wr_addr = run_ff;
                  dl_wr_data = time_ff;
               end
               rrts_pkg::OP_REAP: begin
                  walk_prev_in = IDLE_SLOT;
                  walk_cur_in  = succ_ff[0];
                  fsm_in       = FSM_REAP;
               end
               default: begin
               end
            endcase
         end
         FSM_SCHED: begin
            if (state_ff[walk_cur_ff] == rrts_pkg::ST_READY ||
                state_ff[walk_cur_ff] == rrts_pkg::ST_RUNNING) begin
               done = 1'b1;
               sel  = walk_cur_ff;
            end else begin
               nx        = succ_ff[walk_cur_ff];
               walk_n_in = n_step;
               if (nx == walk_first_ff || n_step >= SLOT_COUNT) begin
                  done = 1'b1;
                  sel  = IDLE_SLOT;
               end else begin
                  walk_cur_in = nx;
               end
            end
            if (done) begin
               if (state_ff[run_ff] == rrts_pkg::ST_RUNNING) begin
                  state_in[run_ff] = rrts_pkg::ST_READY;
               end
               state_in[sel] = rrts_pkg::ST_RUNNING;
               run_in        = sel;
               fsm_in        = FSM_SCAN;
            end
         end
         FSM_REAP: begin
            if (walk_n_ff >= SLOT_COUNT || walk_cur_ff == IDLE_SLOT) begin
               fsm_in = FSM_SCAN;
            end else begin
               cur       = walk_cur_ff;
               par       = parent_ff[cur];
               walk_n_in = n_step;
               reap_it   = (state_ff[cur] == rrts_pkg::ST_TERMINATED) &&
                           (par == PARENT_NONE || par == '0 ||
                            state_ff[par[SW-1:0]] == rrts_pkg::ST_TERMINATED);
               if (reap_it) begin
                  // unlink and orphan its children
                  succ_in[walk_prev_ff] = succ_ff[cur];
                  if (head_ff == cur) begin
                     head_in = walk_prev_ff;
                  end
                  used_in[cur] = 1'b0;
                  for (int k = 0; k < THREAD_SLOTS; k++) begin
                     if (parent_ff[k] == {1'b0, cur}) begin
                        parent_in[k] = PARENT_NONE;
                     end
                  end
               end else begin
                  walk_prev_in = cur;
               end
               walk_cur_in = succ_ff[cur];
            end
         end
         FSM_SCAN: begin
            proc_vld_in = (scan_idx_ff < SLOT_COUNT);
            proc_idx_in = scan_idx_ff[SW-1:0];
            scan_idx_in = scan_idx_ff + CW'(1);
            if (scan_idx_ff == SLOT_COUNT) begin
               fsm_in = FSM_FINISH;
            end
         end
         FSM_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               fg_alive = (fg_pid_ff != rrts_pkg::PID_NONE) && fg_found_ff && !fg_term_ff;
               if (!fg_alive) begin
                  fg_pid_in = rrts_pkg::PID_NONE;
               end
               rsp_code_in  = code_ff;
               rsp_pid_in   = rpid_ff;
               rsp_fstat_in = rrts_pkg::ST_READY;
               case (op_ff)
                  rrts_pkg::OP_WAIT: begin
                     if (!tgt_found_ff) begin
                        rsp_code_in = rrts_pkg::RC_NOT_FOUND;
                     end else if (tgt_state_ff != rrts_pkg::ST_TERMINATED) begin
                        state_in[run_ff]   = rrts_pkg::ST_WAITING;
                        waitfor_in[run_ff] = {1'b0, target_ff};
                     end
                  end
                  rrts_pkg::OP_FIND: begin
                     if (!tgt_found_ff) begin
                        rsp_code_in = rrts_pkg::RC_NOT_FOUND;
                     end else begin
                        rsp_pid_in   = target_ff;
                        rsp_fstat_in = tgt_state_ff;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_cur_in     = pid_ff[run_ff];
               rsp_ualive_in  = ualive_ff;
               rsp_fgalive_in = fg_alive;
               rsp_valid_in   = 1'b1;
               fsm_in         = FSM_IDLE;
            end
         end
         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase

      // scan stage: deadline data for proc_idx arrives this cycle
      if (proc_vld_ff && used_ff[proc_idx_ff]) begin
         st = state_ff[proc_idx_ff];
         if (user_ff[proc_idx_ff] && st != rrts_pkg::ST_TERMINATED) begin
            ualive_in = 1'b1;
         end
         if ({1'b0, pid_ff[proc_idx_ff]} == fg_pid_ff) begin
            fg_found_in = 1'b1;
            fg_term_in  = (st == rrts_pkg::ST_TERMINATED);
         end
         if (pid_ff[proc_idx_ff] == target_ff) begin
            tgt_found_in = 1'b1;
            tgt_state_in = st;
         end
         if (op_ff == rrts_pkg::OP_TICK && st == rrts_pkg::ST_SLEEPING &&
             time_ff >= dl_rd_data) begin
            state_in[proc_idx_ff] = rrts_pkg::ST_READY;
            dl_wr_en   = 1'b1;
            dl_wr_addr = proc_idx_ff;
            dl_wr_data = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < THREAD_SLOTS; k++) begin
            used_ff[k]    <= (k == 0);
            pid_ff[k]     <= '0;
            state_ff[k]   <= (k == 0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_READY;
            user_ff[k]    <= 1'b0;
            parent_ff[k]  <= PARENT_NONE;
            waitfor_ff[k] <= rrts_pkg::PID_NONE;
            succ_ff[k]    <= '0;
         end
         run_ff       <= '0;
         head_ff      <= '0;
         pid_ctr_ff   <= rrts_pkg::PID_FIRST;
         fg_pid_ff    <= rrts_pkg::PID_NONE;
         fsm_ff       <= FSM_IDLE;
         proc_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int k = 0; k < THREAD_SLOTS; k++) begin
            used_ff[k]    <= used_in[k];
            pid_ff[k]     <= pid_in[k];
            state_ff[k]   <= state_in[k];
            user_ff[k]    <= user_in[k];
            parent_ff[k]  <= parent_in[k];
            waitfor_ff[k] <= waitfor_in[k];
            succ_ff[k]    <= succ_in[k];
         end
         run_ff       <= run_in;
         head_ff      <= head_in;
         pid_ctr_ff   <= pid_ctr_in;
         fg_pid_ff    <= fg_pid_in;
         fsm_ff       <= fsm_in;
         proc_vld_ff  <= proc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      is_user_ff     <= is_user_in;
      make_fg_ff     <= make_fg_in;
      target_ff      <= target_in;
      time_ff        <= time_in;
      walk_cur_ff    <= walk_cur_in;
      walk_prev_ff   <= walk_prev_in;
      walk_first_ff  <= walk_first_in;
      walk_n_ff      <= walk_n_in;
      scan_idx_ff    <= scan_idx_in;
      proc_idx_ff    <= proc_idx_in;
      ualive_ff      <= ualive_in;
      fg_found_ff    <= fg_found_in;
      fg_term_ff     <= fg_term_in;
      tgt_found_ff   <= tgt_found_in;
      tgt_state_ff   <= tgt_state_in;
      code_ff        <= code_in;
      rpid_ff        <= rpid_in;
      rsp_code_ff    <= rsp_code_in;
      rsp_pid_ff     <= rsp_pid_in;
      rsp_fstat_ff   <= rsp_fstat_in;
      rsp_cur_ff     <= rsp_cur_in;
      rsp_ualive_ff  <= rsp_ualive_in;
      rsp_fgalive_ff <= rsp_fgalive_in;
   end

   `RRTS_ASSERT_IMPL(a_run_in_ring, clock, reset, 1'b1, used_ff[run_ff], "running slot unlinked")
   `RRTS_ASSERT_IMPL(a_head_in_ring, clock, reset, 1'b1, used_ff[head_ff], "ring head unlinked")
   `RRTS_ASSERT_IMPL(a_pid_ctr_range, clock, reset, 1'b1, pid_ctr_ff <= 17'h10000, "pid counter overrun")
   `RRTS_ASSERT_NEXT(a_accept_to_op, clock, reset, accept, fsm_ff == FSM_OP, "accepted request not started")
   `RRTS_ASSERT_NEXT(a_finish_loads, clock, reset, fsm_ff == FSM_FINISH && (!rsp_valid_ff || rsp_chan.ready), rsp_valid_ff && fsm_ff == FSM_IDLE, "response not loaded")

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the round-robin thread scheduler.
// Needs rrts_pkg, rrts_if and the scheduler RTL; a class-based scoreboard
// mirrors the slot table and checks every response in order.

typedef struct packed {
   rrts_pkg::op_type   operation;
   logic               is_user;
   logic               make_foreground;
   rrts_pkg::pid_type  target_pid;
   rrts_pkg::time_type wake_deadline;
   rrts_pkg::time_type now_time;
} sched_request_type;

typedef struct packed {
   rrts_pkg::result_code_type  result_code;
   rrts_pkg::pid_type          result_pid;
   rrts_pkg::thread_state_type found_status;
   rrts_pkg::pid_type          current_pid;
   logic                       user_alive;
   logic                       foreground_alive;
} sched_response_type;

class sched_scoreboard;
   localparam int SLOTS = 16;
   localparam logic [4:0] PARENT_NONE = 5'd16;

   bit                         used[SLOTS];
   rrts_pkg::pid_type          pid[SLOTS];
   rrts_pkg::thread_state_type state[SLOTS];
   bit                         user[SLOTS];
   logic [4:0]                 parent[SLOTS];
   rrts_pkg::pid_ext_type      wait_for[SLOTS];
   rrts_pkg::time_type         deadline[SLOTS];
   logic [3:0]                 succ[SLOTS];
   logic [3:0]                 running;
   logic [3:0]                 head;
   logic [16:0]                pid_counter;
   rrts_pkg::pid_ext_type      fg_pid;

   sched_response_type expected_rsp[$];
   int                 errors;
   int                 checked;

   function new();
      for (int s = 0; s < SLOTS; s++) begin
         used[s] = 0;
         pid[s] = '0;
         state[s] = rrts_pkg::ST_READY;
         user[s] = 0;
         parent[s] = PARENT_NONE;
         wait_for[s] = rrts_pkg::PID_NONE;
         deadline[s] = '0;
         succ[s] = '0;
      end
      used[0] = 1;
      state[0] = rrts_pkg::ST_RUNNING;
      running = '0;
      head = '0;
      pid_counter = rrts_pkg::PID_FIRST;
      fg_pid = rrts_pkg::PID_NONE;
      errors = 0;
      checked = 0;
   endfunction

   function bit runnable(int s);
      return state[s] == rrts_pkg::ST_READY || state[s] == rrts_pkg::ST_RUNNING;
   endfunction

   function int slot_of(rrts_pkg::pid_ext_type p);
      int s;
      s = head;
      for (int n = 0; n < SLOTS; n++) begin
         if ({1'b0, pid[s]} == p) return s;
         s = succ[s];
         if (s == head) break;
      end
      return -1;
   endfunction

   function void schedule_next();
      int prev, nxt, first, n;
      prev = running;
      nxt = succ[prev];
      first = nxt;
      n = 0;
      while (!runnable(nxt)) begin
         nxt = succ[nxt];
         n++;
         if (nxt == first || n >= SLOTS) begin
            nxt = 0;
            break;
         end
      end
      if (state[prev] == rrts_pkg::ST_RUNNING) state[prev] = rrts_pkg::ST_READY;
      state[nxt] = rrts_pkg::ST_RUNNING;
      running = 4'(nxt);
   endfunction

   function void exit_current();
      int cur, p;
      cur = running;
      if (cur != 0) begin
         p = parent[cur];
         state[cur] = rrts_pkg::ST_TERMINATED;
         if (fg_pid == {1'b0, pid[cur]}) fg_pid = rrts_pkg::PID_NONE;
         if (p < SLOTS && state[p] == rrts_pkg::ST_WAITING &&
             wait_for[p] == {1'b0, pid[cur]}) begin
            state[p] = rrts_pkg::ST_READY;
            wait_for[p] = rrts_pkg::PID_NONE;
         end
      end
      schedule_next();
   endfunction

   function void wake_sleepers(rrts_pkg::time_type now);
      int s;
      s = head;
      for (int n = 0; n < SLOTS; n++) begin
         if (state[s] == rrts_pkg::ST_SLEEPING && now >= deadline[s]) begin
            state[s] = rrts_pkg::ST_READY;
            deadline[s] = '0;
         end
         s = succ[s];
         if (s == head) break;
      end
   endfunction

   function void reap_orphans();
      int prev, cur, p, after, n;
      prev = 0;
      cur = succ[0];
      n = 0;
      while (n < SLOTS && cur != 0) begin
         p = parent[cur];
         if (state[cur] == rrts_pkg::ST_TERMINATED &&
             (p >= SLOTS || p == 0 || state[p] == rrts_pkg::ST_TERMINATED)) begin
            after = succ[cur];
            succ[prev] = 4'(after);
            if (head == cur) head = 4'(prev);
            used[cur] = 0;
            for (int k = 0; k < SLOTS; k++)
               if (parent[k] == cur) parent[k] = PARENT_NONE;
            cur = after;
         end else begin
            prev = cur;
            cur = succ[cur];
         end
         n++;
      end
   endfunction

   function void create_thread(sched_request_type r, ref sched_response_type o);
      int slot;
      slot = 0;
      for (int s = 1; s < SLOTS; s++)
         if (!used[s]) begin
            slot = s;
            break;
         end
      if (slot == 0) begin
         o.result_code = rrts_pkg::RC_TABLE_FULL;
         return;
      end
      if (pid_counter > rrts_pkg::PID_LIMIT) begin
         o.result_code = rrts_pkg::RC_PIDS_EXHAUSTED;
         return;
      end
      used[slot] = 1;
      pid[slot] = pid_counter[15:0];
      pid_counter = pid_counter + 17'd1;
      state[slot] = rrts_pkg::ST_READY;
      user[slot] = r.is_user;
      parent[slot] = r.is_user ? {1'b0, running} : PARENT_NONE;
      wait_for[slot] = rrts_pkg::PID_NONE;
      deadline[slot] = '0;
      succ[slot] = succ[head];
      succ[head] = 4'(slot);
      if (r.make_foreground) fg_pid = {1'b0, pid[slot]};
      o.result_pid = pid[slot];
   endfunction

   function void note_request(sched_request_type r);
      sched_response_type o;
      int f, s;
      o = '0;
      case (r.operation)
         rrts_pkg::OP_CREATE:   create_thread(r, o);
         rrts_pkg::OP_SCHEDULE: schedule_next();
         rrts_pkg::OP_EXIT:     exit_current();
         rrts_pkg::OP_SLEEP: begin
            state[running] = rrts_pkg::ST_SLEEPING;
            deadline[running] = r.wake_deadline;
         end
         rrts_pkg::OP_WAIT: begin
            f = slot_of({1'b0, r.target_pid});
            if (f < 0) o.result_code = rrts_pkg::RC_NOT_FOUND;
            else if (state[f] != rrts_pkg::ST_TERMINATED) begin
               state[running] = rrts_pkg::ST_WAITING;
               wait_for[running] = {1'b0, r.target_pid};
            end
         end
         rrts_pkg::OP_TICK: wake_sleepers(r.now_time);
         rrts_pkg::OP_REAP: reap_orphans();
         default: begin
            f = slot_of({1'b0, r.target_pid});
            if (f < 0) o.result_code = rrts_pkg::RC_NOT_FOUND;
            else begin
               o.result_pid = pid[f];
               o.found_status = state[f];
            end
         end
      endcase
      s = head;
      for (int n = 0; n < SLOTS; n++) begin
         if (user[s] && state[s] != rrts_pkg::ST_TERMINATED) o.user_alive = 1;
         s = succ[s];
         if (s == head) break;
      end
      if (fg_pid != rrts_pkg::PID_NONE) begin
         f = slot_of(fg_pid);
         if (f < 0 || state[f] == rrts_pkg::ST_TERMINATED) fg_pid = rrts_pkg::PID_NONE;
         else o.foreground_alive = 1;
      end
      o.current_pid = pid[running];
      expected_rsp.push_back(o);
   endfunction

   function void check_response(sched_response_type a);
      sched_response_type e;
      if (expected_rsp.size() == 0) begin
         $error("response with no request outstanding");
         errors++;
         return;
      end
      e = expected_rsp.pop_front();
      checked++;
      if (a.result_code !== e.result_code) begin
         $error("result_code expected %0d actual %0d", e.result_code, a.result_code);
         errors++;
      end
      if (a.result_pid !== e.result_pid) begin
         $error("result_pid expected %0d actual %0d", e.result_pid, a.result_pid);
         errors++;
      end
      if (a.found_status !== e.found_status) begin
         $error("found_status expected %0d actual %0d", e.found_status, a.found_status);
         errors++;
      end
      if (a.current_pid !== e.current_pid) begin
         $error("current_pid expected %0d actual %0d", e.current_pid, a.current_pid);
         errors++;
      end
      if (a.user_alive !== e.user_alive) begin
         $error("user_alive expected %0d actual %0d", e.user_alive, a.user_alive);
         errors++;
      end
      if (a.foreground_alive !== e.foreground_alive) begin
         $error("foreground_alive expected %0d actual %0d",
                e.foreground_alive, a.foreground_alive);
         errors++;
      end
   endfunction

   function int pending();
      return expected_rsp.size();
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;

   rrts_req_if req_chan();
   rrts_rsp_if rsp_chan();

   round_robin_thread_scheduler u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sched_scoreboard    sb;
   int                 send_idle_pct;
   int                 rsp_stall_pct;
   bit                 hold_off_request = 1'b0;
   bit                 hold_off_taken = 1'b0;
   int                 hold_off_cycles = 0;
   int                 op_count[8];
   rrts_pkg::time_type sim_now;
   sched_response_type got_rsp;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #20ms;
      $display("testbench timed out");
      $display("testbench failed");
      $finish;
   end

   // Receiver: a long hold-off wins over the random stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_off_request && !hold_off_taken) begin
         rsp_chan.ready  <= 1'b0;
         hold_off_taken  <= 1'b1;
         hold_off_cycles <= 300;
      end else if (hold_off_cycles > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got_rsp.result_code      = rsp_chan.result_code;
         got_rsp.result_pid       = rsp_chan.result_pid;
         got_rsp.found_status     = rsp_chan.found_status;
         got_rsp.current_pid      = rsp_chan.current_pid;
         got_rsp.user_alive       = rsp_chan.user_alive;
         got_rsp.foreground_alive = rsp_chan.foreground_alive;
         sb.check_response(got_rsp);
      end
   end

   task automatic send_request(sched_request_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid           <= 1'b1;
      req_chan.operation       <= r.operation;
      req_chan.is_user         <= r.is_user;
      req_chan.make_foreground <= r.make_foreground;
      req_chan.target_pid      <= r.target_pid;
      req_chan.wake_deadline   <= r.wake_deadline;
      req_chan.now_time        <= r.now_time;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(r);
      op_count[r.operation]++;
   endtask

   task automatic send_op(rrts_pkg::op_type op, logic usr, logic fg, rrts_pkg::pid_type tgt,
                          rrts_pkg::time_type t);
      sched_request_type r;
      r.operation = op;
      r.is_user = usr;
      r.make_foreground = fg;
      r.target_pid = tgt;
      r.wake_deadline = {$urandom, $urandom};
      r.now_time = {$urandom, $urandom};
      if (op == rrts_pkg::OP_SLEEP) r.wake_deadline = t;
      if (op == rrts_pkg::OP_TICK) r.now_time = t;
      send_request(r);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random();
      sched_request_type r;
      int pick;
      r.is_user = 1'($urandom_range(1));
      r.make_foreground = ($urandom_range(3) == 0);
      pick = $urandom_range(99);
      if (pick < 25)      r.operation = rrts_pkg::OP_CREATE;
      else if (pick < 44) r.operation = rrts_pkg::OP_SCHEDULE;
      else if (pick < 56) r.operation = rrts_pkg::OP_EXIT;
      else if (pick < 64) r.operation = rrts_pkg::OP_SLEEP;
      else if (pick < 72) r.operation = rrts_pkg::OP_WAIT;
      else if (pick < 82) r.operation = rrts_pkg::OP_TICK;
      else if (pick < 90) r.operation = rrts_pkg::OP_REAP;
      else                r.operation = rrts_pkg::OP_FIND;
      case ($urandom_range(9))
         0:       r.target_pid = 16'($urandom);
         1:       r.target_pid = '0;
         default: r.target_pid = 16'($urandom_range(sb.pid_counter + 1, 0));
      endcase
      sim_now = sim_now + 64'($urandom_range(8));
      r.wake_deadline = ($urandom_range(7) == 0) ? {$urandom, $urandom}
                                                 : sim_now + 64'($urandom_range(40));
      r.now_time = ($urandom_range(7) == 0) ? {$urandom, $urandom} : sim_now;
      send_request(r);
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      sim_now = '0;
      foreach (op_count[i]) op_count[i] = 0;
      req_chan.valid <= 1'b0;
      req_chan.operation <= rrts_pkg::OP_FIND;
      req_chan.is_user <= 1'b0;
      req_chan.make_foreground <= 1'b0;
      req_chan.target_pid <= '0;
      req_chan.wake_deadline <= '0;
      req_chan.now_time <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every operation, field extremes, not-found and idle cases.
      send_op(rrts_pkg::OP_FIND, 0, 0, 16'd0, '0);
      send_op(rrts_pkg::OP_FIND, 1, 1, 16'hFFFF, '0);
      send_op(rrts_pkg::OP_WAIT, 0, 0, 16'hFFFF, '0);
      send_op(rrts_pkg::OP_EXIT, 0, 0, 16'd0, '0);
      send_op(rrts_pkg::OP_SCHEDULE, 0, 0, 16'd0, '0);
      send_op(rrts_pkg::OP_CREATE, 1, 1, 16'd0, '0);
      send_op(rrts_pkg::OP_CREATE, 0, 0, 16'd0, '0);
      send_op(rrts_pkg::OP_FIND, 0, 0, 16'd1, '0);
      send_op(rrts_pkg::OP_WAIT, 0, 0, 16'd1, '0);
      send_op(rrts_pkg::OP_SCHEDULE, 0, 0, 16'd0, '0);
      send_op(rrts_pkg::OP_EXIT, 0, 0, 16'd0, '0);
      send_op(rrts_pkg::OP_FIND, 0, 0, 16'd0, '0);
      send_op(rrts_pkg::OP_SLEEP, 0, 0, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_op(rrts_pkg::OP_TICK, 0, 0, 16'd0, 64'd0);
      send_op(rrts_pkg::OP_SCHEDULE, 0, 0, 16'd0, '0);
      send_op(rrts_pkg::OP_TICK, 0, 0, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_op(rrts_pkg::OP_WAIT, 0, 0, 16'd2, '0);
      send_op(rrts_pkg::OP_SCHEDULE, 0, 0, 16'd0, '0);
      send_op(rrts_pkg::OP_EXIT, 0, 0, 16'd0, '0);
      send_op(rrts_pkg::OP_REAP, 0, 0, 16'd0, '0);
      send_op(rrts_pkg::OP_FIND, 0, 0, 16'd1, '0);
      send_op(rrts_pkg::OP_WAIT, 0, 0, 16'd1, '0);
      send_op(rrts_pkg::OP_SLEEP, 0, 0, 16'd0, 64'd0);
      send_op(rrts_pkg::OP_SCHEDULE, 0, 0, 16'd0, '0);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 46; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 46; end
            default: begin send_idle_pct = 30; rsp_stall_pct = 30; end
         endcase
         for (int i = 0; i < 206; i++) begin
            if (phase == 2 && i == 50) hold_off_request = 1'b1;
            send_random();
         end
         // Pause the sender until every transfer has come back.
         drain();
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;

      fork
         while (sb.pending() != 0) @(posedge clock);
         begin
            repeat (20000) @(posedge clock);
            $display("responses still outstanding: %0d", sb.pending());
            sb.errors++;
         end
      join_any
      disable fork;
      repeat (40) @(posedge clock);

      $display("covered %0d requests: create %0d schedule %0d exit %0d sleep %0d",
               sb.checked, op_count[rrts_pkg::OP_CREATE], op_count[rrts_pkg::OP_SCHEDULE],
               op_count[rrts_pkg::OP_EXIT], op_count[rrts_pkg::OP_SLEEP]);
      $display("wait %0d tick %0d reap %0d find %0d, under four idle and stall mixes",
               op_count[rrts_pkg::OP_WAIT], op_count[rrts_pkg::OP_TICK],
               op_count[rrts_pkg::OP_REAP], op_count[rrts_pkg::OP_FIND]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
